/* design/hlxfd_pkg.sv */
// ----------------------------------------------------------------------------
// hlxfd_pkg
// Shared types and constants for the header/length/XOR frame decoder.
// ----------------------------------------------------------------------------
package hlxfd_pkg;

  // Fixed frame marker bytes.
  localparam logic [7:0] SYNC0      = 8'h55;  // 'U'
  localparam logic [7:0] SYNC1      = 8'h4E;  // 'N'
  localparam logic [7:0] SYNC2      = 8'h45;  // 'E'
  localparam logic [7:0] SYNC3      = 8'h52;  // 'R'
  localparam logic [7:0] ZERO_MARK  = 8'h00;
  localparam logic [7:0] COLON_MARK = 8'h3A;  // ':'

  // XOR of every fixed header byte; the length byte is folded in later.
  localparam logic [7:0] HDR_CHECK =
    SYNC0 ^ SYNC1 ^ SYNC2 ^ SYNC3 ^ ZERO_MARK ^ COLON_MARK;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] byte_index;
  } res_t;

endpackage

/* design/hlxfd_parse.sv */
// ----------------------------------------------------------------------------
// hlxfd_parse
// Frame hunting state machine: consumes one byte per step and reports the
// result word that the byte causes, if any.
// ----------------------------------------------------------------------------
module hlxfd_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output hlxfd_pkg::res_t   res
);
  import hlxfd_pkg::*;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_N     = 3'd1;
  localparam logic [2:0] PH_E     = 3'd2;
  localparam logic [2:0] PH_R     = 3'd3;
  localparam logic [2:0] PH_LEN   = 3'd4;
  localparam logic [2:0] PH_ZERO  = 3'd5;
  localparam logic [2:0] PH_COLON = 3'd6;
  localparam logic [2:0] PH_BODY  = 3'd7;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] remaining_r, remaining_nxt;
  logic [7:0] check_r, check_nxt;
  logic [7:0] seen_r, seen_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [2:0] hunt;

  // A mismatching byte is looked at again as a possible first sync byte.
  assign hunt = (rx_byte == SYNC0) ? PH_N : PH_HUNT;

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    check_nxt     = check_r;
    seen_nxt      = seen_r;
    cmd_nxt       = cmd_r;
    res           = '0;
    unique case (phase_r)
      PH_HUNT:  phase_nxt = hunt;
      PH_N:     phase_nxt = (rx_byte == SYNC1) ? PH_E : hunt;
      PH_E:     phase_nxt = (rx_byte == SYNC2) ? PH_R : hunt;
      PH_R:     phase_nxt = (rx_byte == SYNC3) ? PH_LEN : hunt;
      PH_LEN: begin
        remaining_nxt = rx_byte;
        phase_nxt     = (rx_byte == 8'd0) ? PH_HUNT : PH_ZERO;
      end
      PH_ZERO:  phase_nxt = (rx_byte == ZERO_MARK) ? PH_COLON : hunt;
      PH_COLON: begin
        if (rx_byte == COLON_MARK) begin
          check_nxt = HDR_CHECK ^ remaining_r;
          seen_nxt  = 8'd0;
          cmd_nxt   = 8'd0;
          phase_nxt = PH_BODY;
        end else begin
          phase_nxt = hunt;
        end
      end
      PH_BODY: begin
        res.valid = 1'b1;
        if (remaining_r > 8'd1) begin
          check_nxt      = check_r ^ rx_byte;
          if (seen_r == 8'd0) begin
            cmd_nxt = rx_byte;
          end
          res.kind       = KIND_PAYLOAD;
          res.data       = rx_byte;
          res.byte_index = seen_r;
          seen_nxt       = seen_r + 8'd1;
          remaining_nxt  = remaining_r - 8'd1;
        end else begin
          // Last byte of the frame is the checksum.
          remaining_nxt  = 8'd0;
          phase_nxt      = PH_HUNT;
          res.kind       = (check_r == rx_byte) ? KIND_GOOD : KIND_BAD;
          res.data       = cmd_r;
          res.byte_index = seen_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      remaining_r <= 8'd0;
      check_r     <= 8'd0;
      seen_r      <= 8'd0;
      cmd_r       <= 8'd0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      check_r     <= check_nxt;
      seen_r      <= seen_nxt;
      cmd_r       <= cmd_nxt;
    end
  end

endmodule

/* design/header_length_xor_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// header_length_xor_frame_decoder_core
// Path: an input word is held in the input register, then the frame state
// update writes its result word into the result register.
// Throughput: one input word per cycle while out_stall does not hold the result.
// Reset: synchronous, active low; the decoder returns to hunting for the
// first sync byte and both registers are emptied.
// ----------------------------------------------------------------------------
module header_length_xor_frame_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  // Received byte stream.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // Decoded payload words and frame results.
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data,
  output logic [7:0] out_byte_index
);
  import hlxfd_pkg::*;

  // Input register. A received byte waits here until the frame state machine
  // processes it.
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // Result register. It drives the output port directly.
  logic       out_vld_r;
  logic [1:0] out_kind_r;
  logic [7:0] out_data_r;
  logic [7:0] out_idx_r;

  logic out_free;
  logic step;
  res_t res;

  // The result register can take a new word when it is empty or when its
  // current word is taken in this cycle.
  assign out_free = !out_vld_r || !out_stall;

  // The held byte is processed whenever the result slot can take whatever
  // it produces. A byte that gives no result still waits for a free slot,
  // which keeps the control simple and costs nothing when the sink keeps up.
  assign step = in_vld_r && out_free;

  // The input register is refilled when it is empty or drained this cycle,
  // so a byte is taken every cycle while the output side flows.
  assign in_stall = in_vld_r && !step;

  hlxfd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_kind_r <= res.kind;
      out_data_r <= res.data;
      out_idx_r  <= res.byte_index;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_kind       = out_kind_r;
  assign out_data       = out_data_r;
  assign out_byte_index = out_idx_r;

endmodule

/* design/hlxfd_chk.sv */
// ----------------------------------------------------------------------------
// hlxfd_chk
// Port-level checks for the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hlxfd_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_data,
  input logic [7:0] out_byte_index
);
  import hlxfd_pkg::*;

  // A stalled input word stays put until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("stalled input word changed");

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
    $stable(out_data) && $stable(out_byte_index))
    else $error("stalled result word changed");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // With the result slot empty the input side never back-pressures.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result slot is empty");

  // A payload position never reaches 255, since the length includes the
  // checksum byte.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PAYLOAD) |-> out_byte_index != 8'hFF)
    else $error("payload position out of range");

endmodule

bind header_length_xor_frame_decoder_core hlxfd_chk u_hlxfd_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_rx_byte     (in_rx_byte),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_data       (out_data),
  .out_byte_index (out_byte_index)
);
